@@ hdl/dfd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the line frame decoder: beat types, mode and result codes,
// register indexes and fixed constants. No dependencies.
package dfd_pkg;

    localparam int FRAME_BITS     = 16;
    localparam int REPLY_BITS     = 20;
    localparam int EDGE_DEPTH_DEF = 64;
    localparam int REL_W          = 24;
    localparam int CENTRE_DIV     = 2 * REPLY_BITS;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_PULSE = 2'd1;
    localparam logic [1:0] MODE_GAP   = 2'd2;
    localparam logic [1:0] MODE_REPLY = 2'd3;

    localparam logic [1:0] KIND_COMMAND = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIDIR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPB       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd4;

    localparam logic [17:0] RECIP_5 = 18'h33333;

    typedef struct packed {
        logic        edge_level;
        logic [31:0] edge_interval;
    } in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [10:0] throttle_payload;
        logic        reply_request;
        logic        check_ok;
        logic [3:0]  check_value;
        logic [15:0] command_word;
        logic [19:0] reply_word;
        logic [3:0]  error_position;
    } out_t;

    typedef struct packed {
        logic              level;
        logic [REL_W-1:0]  rel;
    } edge_t;

endpackage

@@ hdl/dfd_edge_mem.sv @@
`timescale 1ns / 1ps
// Edge store for the telemetry window: one write port, one registered read port.
// Depends on dfd_pkg.
module dfd_edge_mem #(
    parameter int EDGE_DEPTH = dfd_pkg::EDGE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(EDGE_DEPTH)-1:0] wr_addr,
    input  dfd_pkg::edge_t                wr_data,
    input  logic [$clog2(EDGE_DEPTH)-1:0] rd_addr,
    output dfd_pkg::edge_t                rd_data
);
    import dfd_pkg::*;

    edge_t mem_reg [EDGE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

@@ hdl/dfd_reply_walk.sv @@
`timescale 1ns / 1ps
// Sequencer that samples stored edges at the reply bit centres and works out
// the reply length. Depends on dfd_pkg; reads dfd_edge_mem.
module dfd_reply_walk #(
    parameter int EDGE_DEPTH = dfd_pkg::EDGE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            ack,
    input  logic [$clog2(EDGE_DEPTH+1)-1:0] count,
    input  logic [dfd_pkg::REL_W-1:0]       span,
    input  logic                            active,
    output logic [$clog2(EDGE_DEPTH)-1:0]   rd_addr,
    input  dfd_pkg::edge_t                  rd_data,
    output logic                            done,
    output logic [dfd_pkg::REPLY_BITS-1:0]  word,
    output logic [dfd_pkg::REL_W:0]         span_end
);
    import dfd_pkg::*;

    localparam int CW = $clog2(EDGE_DEPTH + 1);
    localparam int AW = $clog2(EDGE_DEPTH);
    localparam int KW = $clog2(REPLY_BITS);
    localparam int XW = REL_W + 7;

    localparam logic [2:0] W_IDLE  = 3'd0;
    localparam logic [2:0] W_FETCH = 3'd1;
    localparam logic [2:0] W_CMP   = 3'd2;
    localparam logic [2:0] W_BIT   = 3'd3;
    localparam logic [2:0] W_MUL   = 3'd4;
    localparam logic [2:0] W_COR   = 3'd5;
    localparam logic [2:0] W_DONE  = 3'd6;

    logic [2:0]            st_reg, st_next;
    logic [CW-1:0]         e_reg, e_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [XW-1:0]         x_reg, x_next;
    logic                  lvl_reg, lvl_next;
    logic [REPLY_BITS-1:0] word_reg, word_next;
    logic [38:0]           prod_reg, prod_next;
    logic [REL_W:0]        end_reg, end_next;
    logic [XW-1:0]         lhs;
    logic [18:0]           q0;
    logic [21:0]           rem;

    assign rd_addr  = e_reg[AW-1:0];
    assign done     = (st_reg == W_DONE);
    assign word     = word_reg;
    assign span_end = end_reg;

    always_comb
    begin
        st_next   = st_reg;
        e_next    = e_reg;
        k_next    = k_reg;
        x_next    = x_reg;
        lvl_next  = lvl_reg;
        word_next = word_reg;
        prod_next = prod_reg;
        end_next  = end_reg;
        lhs       = XW'(({1'b0, rd_data.rel} + 25'd1) * CENTRE_DIV);
        q0        = prod_reg[38:20];
        rem       = {1'b0, span[REL_W-1:3]} - (22'(q0) * 22'd5);
        unique case (st_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    e_next   = '0;
                    k_next   = '0;
                    x_next   = XW'(span);
                    lvl_next = active;
                    st_next  = W_FETCH;
                end
            end
            W_FETCH:
            begin
                st_next = (e_reg < count) ? W_CMP : W_BIT;
            end
            W_CMP:
            begin
                if (lhs <= x_reg)
                begin
                    lvl_next = rd_data.level;
                    e_next   = e_reg + CW'(1);
                    st_next  = W_FETCH;
                end
                else
                begin
                    st_next = W_BIT;
                end
            end
            W_BIT:
            begin
                word_next[REPLY_BITS - 1 - int'(k_reg)] = lvl_reg;
                if (k_reg == KW'(REPLY_BITS - 1))
                begin
                    st_next = W_MUL;
                end
                else
                begin
                    k_next  = k_reg + KW'(1);
                    x_next  = x_reg + XW'({span, 1'b0});
                    st_next = W_FETCH;
                end
            end
            W_MUL:
            begin
                prod_next = span[REL_W-1:3] * RECIP_5;
                st_next   = W_COR;
            end
            W_COR:
            begin
                end_next = {1'b0, span} + (REL_W+1)'(q0) +
                           (REL_W+1)'(rem >= 22'd5);
                st_next  = W_DONE;
            end
            W_DONE:
            begin
                if (ack)
                begin
                    st_next = W_IDLE;
                end
            end
            default:
            begin
                st_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= W_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg    <= e_next;
        k_reg    <= k_next;
        x_reg    <= x_next;
        lvl_reg  <= lvl_next;
        word_reg <= word_next;
        prod_reg <= prod_next;
        end_reg  <= end_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == W_CMP) |-> (e_reg < count))
        else $error("edge index read beyond the stored count");
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg <= KW'(REPLY_BITS - 1)) || (st_reg == W_IDLE))
        else $error("centre index out of range");
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ack) |=> done)
        else $error("walk result dropped before it was taken");
`endif

endmodule

@@ hdl/dshot_frame_decoder_top.sv @@
`timescale 1ns / 1ps
// Top level of the line frame decoder: command frame FSM, registers and result
// register. Depends on dfd_pkg, dfd_edge_mem and dfd_reply_walk.
//
// Channel   Direction  Handshake            Beat
// in        input      in_valid/in_ready    dfd_pkg::in_t  (one line edge)
// out       output     out_valid/out_ready  dfd_pkg::out_t (one result)
// cfg       input      cfg_write            cfg_index, cfg_data
//
// An edge is accepted in ST_ACCEPT and then decoded in ST_EXEC.
// An edge that closes a telemetry window then starts the centre walk, which reads the
// stored edges one at a time through the edge memory's single read port.
// Reset clears all control state; the edge memory needs no clearing.
// Decoding waits while the result register holds a beat that is not taken.
module dshot_frame_decoder_top #(
    parameter int EDGE_DEPTH = dfd_pkg::EDGE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  dfd_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output dfd_pkg::out_t                    out_data,
    input  logic                             cfg_write,
    input  logic [dfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dfd_pkg::*;

    localparam int CW = $clog2(EDGE_DEPTH + 1);
    localparam int AW = $clog2(EDGE_DEPTH);

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_WALK   = 2'd2;

    logic [1:0]       st_reg, st_next;
    logic [31:0]      tick_reg, tick_next;
    logic             level_reg, level_next;
    logic [1:0]       mode_reg, mode_next;
    logic [3:0]       pos_reg, pos_next;
    logic [15:0]      word_reg, word_next;
    logic [31:0]      ps_reg, ps_next;
    logic [31:0]      fe_reg, fe_next;
    logic [31:0]      rs_reg, rs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [REL_W-1:0] last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    out_t             out_reg, out_next;

    logic             bidir_reg;
    logic [15:0]      spb_reg;
    logic [23:0]      gmin_reg, gmax_reg, win_reg;

    logic             active, out_free, do_idle, mem_we, walk_start, walk_ack, walk_done;
    logic [31:0]      fe_use, width, since, rel;
    logic [15:0]      word_b;
    logic [3:0]       chk;
    logic [AW-1:0]    rd_addr;
    edge_t            rd_data, wr_data;
    logic [REPLY_BITS-1:0] reply_word;
    logic [REL_W:0]   span_end;
    logic [REL_W-1:0] span;

    assign active    = ~bidir_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (st_reg == ST_ACCEPT);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign span      = (cnt_reg == '0) ? '0 : last_reg;
    assign walk_ack  = (st_reg == ST_WALK) && walk_done && out_free;

    always_comb
    begin
        st_next        = st_reg;
        tick_next      = tick_reg;
        level_next     = level_reg;
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        word_next      = word_reg;
        ps_next        = ps_reg;
        fe_next        = fe_reg;
        rs_next        = rs_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        do_idle    = 1'b0;
        fe_use     = fe_reg;
        mem_we     = 1'b0;
        walk_start = 1'b0;
        width      = tick_reg - ps_reg;
        rel        = tick_reg - rs_reg;
        word_b     = word_reg;
        if ({width, 1'b0} > {17'd0, spb_reg})
        begin
            word_b[pos_reg] = 1'b1;
        end
        chk = word_b[7:4] ^ word_b[11:8] ^ word_b[15:12];
        if (bidir_reg)
        begin
            chk = ~chk;
        end
        wr_data.level = level_reg;
        wr_data.rel   = rel[REL_W-1:0];
        unique case (st_reg)
            ST_ACCEPT:
            begin
                if (in_valid)
                begin
                    tick_next  = tick_reg + in_data.edge_interval;
                    level_next = in_data.edge_level;
                    st_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    st_next = ST_ACCEPT;
                    unique case (mode_reg)
                        MODE_PULSE:
                        begin
                            if (level_reg != active)
                            begin
                                word_next = word_b;
                                if (35'(width) * 35'd5 < 35'(spb_reg))
                                begin
                                    out_valid_next = 1'b1;
                                    out_next = '0;
                                    out_next.result_kind    = KIND_ERROR;
                                    out_next.error_position = pos_reg;
                                    mode_next = MODE_IDLE;
                                    pos_next  = 4'(FRAME_BITS - 1);
                                    word_next = '0;
                                end
                                else if (pos_reg == '0)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next = '0;
                                    out_next.result_kind      = KIND_COMMAND;
                                    out_next.throttle_payload = word_b[15:5];
                                    out_next.reply_request    = word_b[4];
                                    out_next.check_ok         = (word_b[3:0] == chk);
                                    out_next.check_value      = chk;
                                    out_next.command_word     = word_b;
                                    fe_next   = tick_reg;
                                    mode_next = MODE_IDLE;
                                    pos_next  = 4'(FRAME_BITS - 1);
                                    word_next = '0;
                                end
                                else
                                begin
                                    pos_next  = pos_reg - 4'd1;
                                    ps_next   = tick_reg;
                                    mode_next = MODE_GAP;
                                end
                            end
                        end
                        MODE_GAP:
                        begin
                            mode_next = MODE_IDLE;
                            do_idle   = 1'b1;
                            if ({width, 1'b0} > 33'(spb_reg) * 33'd3)
                            begin
                                out_valid_next = 1'b1;
                                out_next = '0;
                                out_next.result_kind    = KIND_ERROR;
                                out_next.error_position = pos_reg + 4'd1;
                                pos_next  = 4'(FRAME_BITS - 1);
                                word_next = '0;
                            end
                        end
                        MODE_REPLY:
                        begin
                            if (rel < {8'd0, win_reg})
                            begin
                                if (cnt_reg < CW'(EDGE_DEPTH))
                                begin
                                    mem_we    = 1'b1;
                                    cnt_next  = cnt_reg + CW'(1);
                                    last_next = rel[REL_W-1:0];
                                end
                            end
                            else
                            begin
                                walk_start = 1'b1;
                                st_next    = ST_WALK;
                            end
                        end
                        default:
                        begin
                            do_idle = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (walk_ack)
                begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    out_next.result_kind = KIND_REPLY;
                    out_next.reply_word  = reply_word;
                    fe_next   = rs_reg + 32'(span_end);
                    fe_use    = fe_next;
                    mode_next = MODE_IDLE;
                    pos_next  = 4'(FRAME_BITS - 1);
                    word_next = '0;
                    do_idle   = 1'b1;
                    st_next   = ST_ACCEPT;
                end
            end
            default:
            begin
                st_next = ST_ACCEPT;
            end
        endcase
        since = tick_reg - fe_use;
        if (do_idle && (level_reg == active))
        begin
            if (bidir_reg && (since >= {8'd0, gmin_reg}) && (since <= {8'd0, gmax_reg}))
            begin
                mode_next = MODE_REPLY;
                rs_next   = tick_reg;
                cnt_next  = '0;
                pos_next  = 4'(FRAME_BITS - 1);
                word_next = '0;
            end
            else
            begin
                ps_next   = tick_reg;
                mode_next = MODE_PULSE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_ACCEPT;
            tick_reg      <= '0;
            level_reg     <= 1'b0;
            mode_reg      <= MODE_IDLE;
            pos_reg       <= 4'(FRAME_BITS - 1);
            word_reg      <= '0;
            ps_reg        <= '0;
            fe_reg        <= '0;
            rs_reg        <= '0;
            cnt_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            bidir_reg     <= 1'b0;
            spb_reg       <= 16'd40;
            gmin_reg      <= 24'd360;
            gmax_reg      <= 24'd1080;
            win_reg       <= 24'd768;
        end
        else
        begin
            st_reg        <= st_next;
            tick_reg      <= tick_next;
            level_reg     <= level_next;
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            word_reg      <= word_next;
            ps_reg        <= ps_next;
            fe_reg        <= fe_next;
            rs_reg        <= rs_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_BIDIR:   bidir_reg <= cfg_data[0];
                    CFG_SPB:     spb_reg   <= cfg_data[15:0];
                    CFG_GAP_MIN: gmin_reg  <= cfg_data;
                    CFG_GAP_MAX: gmax_reg  <= cfg_data;
                    CFG_WINDOW:  win_reg   <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    dfd_edge_mem #(
        .EDGE_DEPTH (EDGE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dfd_reply_walk #(
        .EDGE_DEPTH (EDGE_DEPTH)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (walk_start),
        .ack      (walk_ack),
        .count    (cnt_reg),
        .span     (span),
        .active   (active),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .done     (walk_done),
        .word     (reply_word),
        .span_end (span_end)
    );

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(EDGE_DEPTH))
        else $error("edge count beyond the store depth");
    a_gap_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_GAP) |-> (pos_reg != 4'(FRAME_BITS - 1)))
        else $error("gap state with no bit received");
    a_done_walk: assert property (@(posedge clk) disable iff (!rst_n)
        walk_done |-> (st_reg == ST_WALK))
        else $error("reply walk finished outside the walk state");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_reg))
        else $error("pending result overwritten");
`endif

endmodule
